FILE: src/alst_pkg.sv
`default_nettype none

package alst_pkg;

    localparam int CAPACITY = 128;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 3;
    localparam int LEN_W    = 8;
    // wide enough for position and count plus one without overflow
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_BADPOS     = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOTFOUND   = 3'd3,
        ST_NONEIGHBOR = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic eval;
        logic run;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic quick;
        logic run_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/array_list_engine.sv
// Flow: an item that touches no entry (clear, rejected position, full list, empty search,
//   append) goes from EVAL straight to FIN; any other item first walks n entries in RUN,
//   n being at most the list length.
// Occupancy: one item in flight; the next transfer is taken once the result is committed
//   to the output register; the walk is paced at one entry per cycle by the entry RAM's
//   single read port.
// Reset: synchronous active low; empties the list and drops any pending result.
`default_nettype none

module array_list_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic        [alst_pkg::OP_W-1:0]  i_operation,
    input  wire logic        [alst_pkg::POS_W-1:0] i_position,
    input  wire logic signed [alst_pkg::VAL_W-1:0] i_value,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic             [alst_pkg::ST_W-1:0]  o_status,
    output logic signed      [alst_pkg::VAL_W-1:0] o_value_out,
    output logic             [alst_pkg::POS_W-1:0] o_found_position,
    output logic             [alst_pkg::LEN_W-1:0] o_length,
    output logic                                   o_empty_res
);

    // The controller walks IDLE -> EVAL -> RUN -> FIN. EVAL checks the
    // position against the length and sets up the walk; RUN streams reads
    // through the entry RAM, one address per cycle, and acts on each word
    // in the cycle after its read (shift up, shift down, capture or compare); FIN
    // commits the new length and the result into the output register.
    // The output register lets a new transfer in while a result waits.
    alst_pkg::t_cmd cmd;
    alst_pkg::t_sts sts;

    alst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    alst_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_status         (o_status),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_length         (o_length),
        .o_empty_res      (o_empty_res)
    );

endmodule

`default_nettype wire

FILE: src/alst_ram.sv
`default_nettype none

module alst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/alst_ctrl.sv
`default_nettype none

module alst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    input  wire alst_pkg::t_sts i_sts,
    output alst_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_RUN  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   slot_free;

    assign slot_free = !r_ovalid || i_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_valid;
        o_cmd.eval   = (r_state == S_EVAL);
        o_cmd.run    = (r_state == S_RUN);
        o_cmd.commit = (r_state == S_FIN) && slot_free;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.quick ? S_FIN : S_RUN;
            end
            S_RUN: begin
                if (i_sts.run_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // a new result replaces the old one only once it is taken
        if (o_cmd.commit) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

endmodule

`default_nettype wire

FILE: src/alst_dp.sv
`default_nettype none

module alst_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire alst_pkg::t_cmd                      i_cmd,
    output alst_pkg::t_sts                           o_sts,
    input  wire logic        [alst_pkg::OP_W-1:0]    i_operation,
    input  wire logic        [alst_pkg::POS_W-1:0]   i_position,
    input  wire logic signed [alst_pkg::VAL_W-1:0]   i_value,
    output logic             [alst_pkg::ST_W-1:0]    o_status,
    output logic signed      [alst_pkg::VAL_W-1:0]   o_value_out,
    output logic             [alst_pkg::POS_W-1:0]   o_found_position,
    output logic             [alst_pkg::LEN_W-1:0]   o_length,
    output logic                                     o_empty_res
);

    localparam int CW = alst_pkg::CNT_W;

    alst_pkg::t_op     r_op, n_op;
    logic [alst_pkg::POS_W-1:0] r_pos, n_pos;
    logic signed [alst_pkg::VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ra, n_ra;
    logic [CW-1:0]     r_left, n_left;
    logic              r_up, n_up;
    logic              r_dv, n_dv;
    logic [CW-1:0]     r_da, n_da;
    logic signed [alst_pkg::VAL_W-1:0] r_prev, n_prev;
    logic              r_found, n_found;
    logic              r_pend, n_pend;
    alst_pkg::t_status r_status, n_status;
    logic signed [alst_pkg::VAL_W-1:0] r_vout, n_vout;
    logic [CW-1:0]     r_fpos, n_fpos;

    logic [alst_pkg::ST_W-1:0]  r_ostatus;
    logic signed [alst_pkg::VAL_W-1:0] r_ovalue;
    logic [alst_pkg::POS_W-1:0] r_ofpos;
    logic [alst_pkg::LEN_W-1:0] r_olen;
    logic                       r_oempty;

    logic [alst_pkg::POS_W-1:0] pos_dec;
    logic [CW-1:0]              pos_m1;
    logic [alst_pkg::CMP_W-1:0] pos_x, cnt_x;
    logic                       bad_ins, bad_rd, full, issue;
    logic [CW-1:0]              da_inc, da_dec;

    logic                       ram_we;
    logic [alst_pkg::ADDR_W-1:0] ram_waddr;
    logic signed [alst_pkg::VAL_W-1:0] ram_wdata, rd_data;

    alst_ram #(
        .WIDTH (alst_pkg::VAL_W),
        .DEPTH (alst_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ra[alst_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign pos_dec = r_pos - alst_pkg::POS_W'(1);
    assign pos_m1  = CW'(pos_dec);
    assign pos_x   = alst_pkg::CMP_W'(r_pos);
    assign cnt_x   = alst_pkg::CMP_W'(r_count);
    assign bad_ins = (r_pos == '0) || (pos_x > cnt_x + alst_pkg::CMP_W'(1));
    assign bad_rd  = (r_pos == '0) || (pos_x > cnt_x);
    assign full    = (r_count == CW'(alst_pkg::CAPACITY));
    assign issue   = i_cmd.run && (r_left != '0);
    assign da_inc  = r_da + CW'(1);
    assign da_dec  = r_da - CW'(1);

    always_comb begin
        n_op     = r_op;
        n_pos    = r_pos;
        n_val    = r_val;
        n_count  = r_count;
        n_ra     = r_ra;
        n_left   = r_left;
        n_up     = r_up;
        n_da     = r_ra;
        n_dv     = issue;
        n_prev   = r_prev;
        n_found  = r_found;
        n_pend   = r_pend;
        n_status = r_status;
        n_vout   = r_vout;
        n_fpos   = r_fpos;
        ram_we    = 1'b0;
        ram_waddr = pos_m1[alst_pkg::ADDR_W-1:0];
        ram_wdata = r_val;

        if (i_cmd.load) begin
            n_op  = alst_pkg::t_op'(i_operation);
            n_pos = i_position;
            n_val = i_value;
        end

        if (i_cmd.eval) begin
            n_status = alst_pkg::ST_OK;
            n_vout   = '0;
            n_fpos   = '0;
            n_found  = 1'b0;
            n_pend   = 1'b0;
            n_left   = '0;
            n_up     = 1'b1;
            n_ra     = '0;
            case (r_op)
                alst_pkg::OP_INSERT: begin
                    if (bad_ins) begin
                        n_status = alst_pkg::ST_BADPOS;
                    end else if (full) begin
                        n_status = alst_pkg::ST_FULL;
                    end else if (pos_m1 != r_count) begin
                        // walk from the tail down to the insert point
                        n_ra   = r_count - CW'(1);
                        n_left = r_count - pos_m1;
                        n_up   = 1'b0;
                    end
                end
                alst_pkg::OP_DELETE: begin
                    if (bad_rd) begin
                        n_status = alst_pkg::ST_BADPOS;
                    end else begin
                        n_ra   = pos_m1;
                        n_left = r_count - pos_m1;
                    end
                end
                alst_pkg::OP_GET: begin
                    if (bad_rd) begin
                        n_status = alst_pkg::ST_BADPOS;
                    end else begin
                        n_ra   = pos_m1;
                        n_left = CW'(1);
                    end
                end
                alst_pkg::OP_LOCATE, alst_pkg::OP_PRED, alst_pkg::OP_SUCC: begin
                    n_status = alst_pkg::ST_NOTFOUND;
                    n_left   = r_count;
                end
                default: ;
            endcase
        end

        if (issue) begin
            n_ra   = r_up ? r_ra + CW'(1) : r_ra - CW'(1);
            n_left = r_left - CW'(1);
        end

        if (r_dv) begin
            case (r_op)
                alst_pkg::OP_INSERT: begin
                    ram_we    = 1'b1;
                    ram_waddr = da_inc[alst_pkg::ADDR_W-1:0];
                    ram_wdata = rd_data;
                end
                alst_pkg::OP_DELETE: begin
                    if (r_da == pos_m1) begin
                        n_vout = rd_data;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = da_dec[alst_pkg::ADDR_W-1:0];
                        ram_wdata = rd_data;
                    end
                end
                alst_pkg::OP_GET: begin
                    n_vout = rd_data;
                end
                alst_pkg::OP_LOCATE, alst_pkg::OP_PRED, alst_pkg::OP_SUCC: begin
                    n_prev = rd_data;
                    if (r_pend) begin
                        n_vout   = rd_data;
                        n_status = alst_pkg::ST_OK;
                        n_pend   = 1'b0;
                    end else if (!r_found && (rd_data == r_val)) begin
                        n_found = 1'b1;
                        n_left  = '0;
                        if (r_op == alst_pkg::OP_LOCATE) begin
                            n_fpos   = da_inc;
                            n_status = alst_pkg::ST_OK;
                        end else if (r_op == alst_pkg::OP_PRED) begin
                            if (r_da == '0) begin
                                n_status = alst_pkg::ST_NONEIGHBOR;
                            end else begin
                                n_vout   = r_prev;
                                n_status = alst_pkg::ST_OK;
                            end
                        end else if (da_inc >= r_count) begin
                            n_status = alst_pkg::ST_NONEIGHBOR;
                        end else begin
                            // the next entry is already being read
                            n_pend = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.commit) begin
            if (r_status == alst_pkg::ST_OK) begin
                case (r_op)
                    alst_pkg::OP_INSERT: begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_m1[alst_pkg::ADDR_W-1:0];
                        ram_wdata = r_val;
                        n_count   = r_count + CW'(1);
                    end
                    alst_pkg::OP_DELETE: n_count = r_count - CW'(1);
                    alst_pkg::OP_CLEAR:  n_count = '0;
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.quick    = (n_left == '0);
    assign o_sts.run_done = (r_left == '0) && !r_dv && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_dv    <= 1'b0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
            r_dv    <= n_dv;
            r_pend  <= n_pend;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ra     <= n_ra;
        r_up     <= n_up;
        r_da     <= n_da;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_fpos   <= n_fpos;
        if (i_cmd.commit) begin
            r_ostatus <= r_status;
            r_ovalue  <= r_vout;
            r_ofpos   <= alst_pkg::POS_W'(r_fpos);
            r_olen    <= alst_pkg::LEN_W'(n_count);
            r_oempty  <= (n_count == '0);
        end
    end

    assign o_status         = r_ostatus;
    assign o_value_out      = r_ovalue;
    assign o_found_position = r_ofpos;
    assign o_length         = r_olen;
    assign o_empty_res      = r_oempty;

endmodule

`default_nettype wire

FILE: src/alst_checker.sv
`default_nettype none

module alst_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_ready,
    input wire logic        [alst_pkg::OP_W-1:0]  i_operation,
    input wire logic        [alst_pkg::POS_W-1:0] i_position,
    input wire logic signed [alst_pkg::VAL_W-1:0] i_value,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic        [alst_pkg::ST_W-1:0]  o_status,
    input wire logic signed [alst_pkg::VAL_W-1:0] o_value_out,
    input wire logic        [alst_pkg::POS_W-1:0] o_found_position,
    input wire logic        [alst_pkg::LEN_W-1:0] o_length,
    input wire logic                              o_empty_res
);

    logic unused_ok;
    assign unused_ok = ^{i_operation, i_position, i_value};

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_value_out)
            && $stable(o_length))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transfer taken while an item is in work");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_empty_res == (o_length == '0)))
        else $error("empty flag disagrees with length");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != alst_pkg::ST_OK)
            |-> (o_value_out == '0) && (o_found_position == '0))
        else $error("failed result carries data");

endmodule

bind array_list_engine alst_checker u_alst_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W     = alst_pkg::OP_W;
    localparam int POS_W    = alst_pkg::POS_W;
    localparam int VAL_W    = alst_pkg::VAL_W;
    localparam int ST_W     = alst_pkg::ST_W;
    localparam int LEN_W    = alst_pkg::LEN_W;
    localparam int CAPACITY = alst_pkg::CAPACITY;

    // Opcode 7 is not defined by the block; it must be answered as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;
    localparam int              HOLD_CYCLES = 400;      // well past one full walk
    localparam int              CYCLE_LIMIT = 1000000;

    // One list operation as presented on the input channel.
    typedef struct {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } t_list_op;

    // One answer as it should appear on the result channel.
    typedef struct {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        found;
        logic [LEN_W-1:0]        length;
        logic                    empty;
    } t_list_reply;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic [OP_W-1:0]         i_operation = '0;
    logic [POS_W-1:0]        i_position  = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    i_ready     = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic [ST_W-1:0]         o_status;
    logic signed [VAL_W-1:0] o_value_out;
    logic [POS_W-1:0]        o_found_position;
    logic [LEN_W-1:0]        o_length;
    logic                    o_empty_res;

    array_list_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_length         (o_length),
        .o_empty_res      (o_empty_res)
    );

    // Operations waiting to be sent, and answers the list should still give.
    t_list_op                pending_ops[$];
    t_list_reply             awaited_replies[$];
    // Shadow copy of the stored list; index 0 is position 1.
    logic signed [VAL_W-1:0] shadow_list[$];

    // Idle rates in percent for each side; changed between phases.
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    // Long receiver hold-off: the stimulus raises hold_reqs, the ready
    // process answers by counting down hold_left.
    int          hold_reqs  = 0;
    int          hold_taken = 0;
    int          hold_left  = 0;

    logic        in_taken   = 1'b0;  // input transfer happened at the last rising edge
    int          cycle_count = 0;
    int          errors      = 0;
    int          ops_sent    = 0;
    int          replies_checked = 0;
    int          peak_length = 0;
    int          status_seen[8];

    // Length the list will have once every queued operation is applied;
    // steers the random positions toward useful ranges.
    int          planned_len = 0;
    bit          filling     = 1'b1;
    int          mixed_left  = 0;
    int          full_burst  = 0;

    t_list_op    drv_op;
    t_list_op    mon_op;
    t_list_reply want;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH result %0d: %s", $time, replies_checked, what);
        errors++;
    endtask

    task automatic check_field(string name, logic [VAL_W-1:0] got, logic [VAL_W-1:0] exp_v);
        if (got !== exp_v)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_v));
    endtask

    // Apply one operation to the shadow list and return the answer it gives.
    function automatic t_list_reply apply_to_shadow_list(t_list_op c);
        t_list_reply r;
        int          p;
        int          n;
        int          hit;
        r   = '{alst_pkg::ST_OK, '0, '0, '0, 1'b0};
        p   = int'(c.pos);
        n   = shadow_list.size();
        hit = n;
        // first match for the searching operations
        for (int k = n - 1; k >= 0; k--) begin
            if (shadow_list[k] == c.val)
                hit = k;
        end
        case (c.op)
            alst_pkg::OP_INSERT: begin
                if (p < 1 || p > n + 1)
                    r.status = alst_pkg::ST_BADPOS;
                else if (n >= CAPACITY)
                    r.status = alst_pkg::ST_FULL;
                else
                    shadow_list.insert(p - 1, c.val);
            end
            alst_pkg::OP_DELETE: begin
                if (p < 1 || p > n) begin
                    r.status = alst_pkg::ST_BADPOS;
                end else begin
                    r.value = shadow_list[p - 1];
                    shadow_list.delete(p - 1);
                end
            end
            alst_pkg::OP_GET: begin
                if (p < 1 || p > n)
                    r.status = alst_pkg::ST_BADPOS;
                else
                    r.value = shadow_list[p - 1];
            end
            alst_pkg::OP_LOCATE: begin
                if (hit >= n)
                    r.status = alst_pkg::ST_NOTFOUND;
                else
                    r.found = POS_W'(hit + 1);
            end
            alst_pkg::OP_PRED: begin
                if (hit >= n)
                    r.status = alst_pkg::ST_NOTFOUND;
                else if (hit == 0)
                    r.status = alst_pkg::ST_NONEIGHBOR;
                else
                    r.value = shadow_list[hit - 1];
            end
            alst_pkg::OP_SUCC: begin
                if (hit >= n)
                    r.status = alst_pkg::ST_NOTFOUND;
                else if (hit + 1 >= n)
                    r.status = alst_pkg::ST_NONEIGHBOR;
                else
                    r.value = shadow_list[hit + 1];
            end
            alst_pkg::OP_CLEAR: begin
                shadow_list.delete();
            end
            default: ;
        endcase
        r.length = LEN_W'(shadow_list.size());
        r.empty  = (shadow_list.size() == 0);
        return r;
    endfunction

    // Queue one operation and track the length it leaves behind.
    task automatic queue_op(logic [OP_W-1:0] op, int pos, int val);
        t_list_op c;
        c.op  = op;
        c.pos = POS_W'(pos);
        c.val = val;
        pending_ops.push_back(c);
        case (op)
            alst_pkg::OP_INSERT: if (pos >= 1 && pos <= planned_len + 1 &&
                                     planned_len < CAPACITY)
                                     planned_len++;
            alst_pkg::OP_DELETE: if (pos >= 1 && pos <= planned_len)
                                     planned_len--;
            alst_pkg::OP_CLEAR:  planned_len = 0;
            default: ;
        endcase
    endtask

    // Mostly small values so searches hit and duplicates occur, some extremes,
    // some fully random words.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(0, 15) - 4;
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    // Random operations: grow the list until it is full, probe the full list,
    // then wander around mid-size for a while, and grow again.
    task automatic queue_random(int count);
        int unsigned     r;
        int unsigned     r2;
        logic [OP_W-1:0] op;
        int              pos;
        for (int i = 0; i < count; i++) begin
            if (filling && planned_len >= CAPACITY) begin
                filling    = 1'b0;
                full_burst = 3;
                mixed_left = $urandom_range(40, 100);
            end
            r   = $urandom_range(0, 99);
            r2  = $urandom_range(0, 9);
            pos = $urandom_range(0, 255);
            if (full_burst > 0) begin
                // a good position gets a full-list reject, a bad one must
                // still report the bad position first
                op = alst_pkg::OP_INSERT;
                case (full_burst)
                    3:       pos = $urandom_range(1, planned_len + 1);
                    2:       pos = 0;
                    default: pos = 255;
                endcase
                full_burst--;
            end else if (r < 3) begin
                // noise: any opcode, any position
                op = OP_W'($urandom_range(0, 7));
            end else begin
                r = $urandom_range(0, 99);
                if (filling) begin
                    if (r < 62)      op = alst_pkg::OP_INSERT;
                    else if (r < 70) op = alst_pkg::OP_DELETE;
                    else if (r < 78) op = alst_pkg::OP_GET;
                    else if (r < 86) op = alst_pkg::OP_LOCATE;
                    else if (r < 93) op = alst_pkg::OP_PRED;
                    else             op = alst_pkg::OP_SUCC;
                end else begin
                    if (r < 28)      op = alst_pkg::OP_INSERT;
                    else if (r < 52) op = alst_pkg::OP_DELETE;
                    else if (r < 66) op = alst_pkg::OP_GET;
                    else if (r < 78) op = alst_pkg::OP_LOCATE;
                    else if (r < 88) op = alst_pkg::OP_PRED;
                    else if (r < 98) op = alst_pkg::OP_SUCC;
                    else             op = alst_pkg::OP_CLEAR;
                end
                if (op == alst_pkg::OP_INSERT) begin
                    if (r2 == 0)
                        pos = ($urandom_range(0, 1) != 0) ? 0 :
                              $urandom_range(planned_len + 2, 255);
                    else if (r2 <= 3)
                        pos = planned_len + 1;
                    else if (r2 == 4)
                        pos = 1;
                    else
                        pos = $urandom_range(1, planned_len + 1);
                end else if (op == alst_pkg::OP_DELETE || op == alst_pkg::OP_GET) begin
                    if (r2 == 0 || planned_len == 0)
                        pos = ($urandom_range(0, 1) != 0) ? 0 :
                              $urandom_range(planned_len + 1, 255);
                    else if (r2 == 1)
                        pos = planned_len;
                    else if (r2 == 2)
                        pos = 1;
                    else
                        pos = $urandom_range(1, planned_len);
                end
            end
            queue_op(op, pos, pick_value());
            if (!filling && full_burst == 0) begin
                mixed_left--;
                if (mixed_left <= 0)
                    filling = 1'b1;
            end
        end
    endtask

    // Driver: present the next operation at the falling edge once the current
    // one has been transferred; hold valid and payload until then.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                drv_op = pending_ops.pop_front();
                i_valid     <= 1'b1;
                i_operation <= drv_op.op;
                i_position  <= drv_op.pos;
                i_value     <= drv_op.val;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_reqs) begin
            hold_taken <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Monitor: check each result transfer against the oldest awaited answer,
    // then predict the answer for an input transfer on the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("result with nothing awaited, status %0d",
                                              o_status));
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("status", VAL_W'(o_status), VAL_W'(want.status));
                    check_field("value_out", o_value_out, want.value);
                    check_field("found_position", VAL_W'(o_found_position),
                                VAL_W'(want.found));
                    check_field("length", VAL_W'(o_length), VAL_W'(want.length));
                    check_field("empty_res", VAL_W'(o_empty_res), VAL_W'(want.empty));
                    status_seen[want.status]++;
                    if (int'(want.length) > peak_length)
                        peak_length = int'(want.length);
                    replies_checked++;
                end
            end
            if (i_valid && o_ready) begin
                mon_op.op  = i_operation;
                mon_op.pos = i_position;
                mon_op.val = i_value;
                awaited_replies.push_back(apply_to_shadow_list(mon_op));
                ops_sent++;
            end
            in_taken <= i_valid && o_ready;
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1: sender idles lightly, receiver stalls often.
        send_idle = 31;
        recv_idle = 64;

        // Directed: empty list, bad positions, both ends, neighbors at the
        // edges, the unused opcode and clear.
        queue_op(alst_pkg::OP_GET,    1,   0);             // nothing stored
        queue_op(alst_pkg::OP_DELETE, 1,   0);
        queue_op(alst_pkg::OP_LOCATE, 0,   5);             // search on empty list
        queue_op(alst_pkg::OP_PRED,   0,   5);
        queue_op(alst_pkg::OP_SUCC,   0,   5);
        queue_op(alst_pkg::OP_INSERT, 0,   1);             // position zero
        queue_op(alst_pkg::OP_INSERT, 2,   1);             // past the end
        queue_op(alst_pkg::OP_INSERT, 1,   32'sh7FFF_FFFF);
        queue_op(alst_pkg::OP_INSERT, 2,   32'sh8000_0000); // append
        queue_op(alst_pkg::OP_INSERT, 1,   0);             // front
        queue_op(alst_pkg::OP_INSERT, 2,   -32'sd1);       // middle: 0, -1, max, min
        queue_op(alst_pkg::OP_GET,    4,   0);
        queue_op(alst_pkg::OP_GET,    5,   0);
        queue_op(alst_pkg::OP_LOCATE, 255, 32'sh7FFF_FFFF);
        queue_op(alst_pkg::OP_LOCATE, 0,   7);             // miss
        queue_op(alst_pkg::OP_PRED,   0,   0);             // match is first entry
        queue_op(alst_pkg::OP_PRED,   0,   -32'sd1);
        queue_op(alst_pkg::OP_SUCC,   0,   32'sh8000_0000); // match is last entry
        queue_op(alst_pkg::OP_SUCC,   0,   32'sh7FFF_FFFF);
        queue_op(alst_pkg::OP_INSERT, 255, 9);
        queue_op(alst_pkg::OP_DELETE, 4,   0);             // last entry
        queue_op(alst_pkg::OP_DELETE, 1,   0);             // first entry
        queue_op(alst_pkg::OP_DELETE, 0,   0);
        queue_op(OP_UNUSED,           255, -32'sd1);
        queue_op(alst_pkg::OP_CLEAR,  0,   0);
        queue_op(alst_pkg::OP_CLEAR,  255, 0);             // clear on empty list

        queue_random(240);
        while (pending_ops.size() != 0) @(posedge i_clk);

        // Phase 2: the other way round.
        send_idle = 64;
        recv_idle = 31;
        queue_random(242);
        while (pending_ops.size() != 0) @(posedge i_clk);

        // Phase 3: no idling, plus one long receiver hold-off so the block
        // backs up and drops its input ready.
        send_idle = 0;
        recv_idle = 0;
        queue_random(242);
        hold_reqs = hold_reqs + 1;

        while (pending_ops.size() != 0 || i_valid || awaited_replies.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last one
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("summary: %0d operations sent, %0d results checked, peak length %0d",
                 ops_sent, replies_checked, peak_length);
        $display("summary: ok %0d, bad position %0d, full %0d, not found %0d, no neighbor %0d",
                 status_seen[alst_pkg::ST_OK], status_seen[alst_pkg::ST_BADPOS],
                 status_seen[alst_pkg::ST_FULL], status_seen[alst_pkg::ST_NOTFOUND],
                 status_seen[alst_pkg::ST_NONEIGHBOR]);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
